[rtl/e8alu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package e8alu_pkg;

    localparam int ModeWidth  = 5;
    localparam int WordWidth  = 16;
    localparam int ByteWidth  = 8;
    localparam int InTdataW   = 40;
    localparam int OutTdataW  = 24;

    typedef enum logic [ModeWidth-1:0] {
        MODE_ADD        = 5'd0,
        MODE_ADC        = 5'd1,
        MODE_SUB        = 5'd2,
        MODE_SBC        = 5'd3,
        MODE_AND        = 5'd4,
        MODE_XOR        = 5'd5,
        MODE_OR         = 5'd6,
        MODE_CP         = 5'd7,
        MODE_INC8       = 5'd8,
        MODE_DEC8       = 5'd9,
        MODE_RLCA       = 5'd10,
        MODE_RRCA       = 5'd11,
        MODE_RLA        = 5'd12,
        MODE_RRA        = 5'd13,
        MODE_DAA        = 5'd14,
        MODE_CPL        = 5'd15,
        MODE_SCF        = 5'd16,
        MODE_CCF        = 5'd17,
        MODE_ADD16      = 5'd18,
        MODE_SP_E8      = 5'd19,
        MODE_INC16      = 5'd20,
        MODE_DEC16      = 5'd21,
        MODE_LOAD_FLAGS = 5'd22
    } mode_t;

    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } flags_t;

    typedef struct packed {
        logic [WordWidth-1:0] value;
        logic                 write_back;
        flags_t               flags;
    } alu_result_t;

    localparam logic [ByteWidth-1:0] DaaLowAdj  = 8'h06;
    localparam logic [ByteWidth-1:0] DaaHighAdj = 8'h60;
    localparam logic [ByteWidth-1:0] DaaLimit   = 8'h99;
    localparam logic [3:0]           NibbleMax  = 4'h9;

endpackage

`default_nettype wire

[rtl/e8alu_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module e8alu_core (
    input  wire logic [e8alu_pkg::ModeWidth-1:0] mode,
    input  wire logic [e8alu_pkg::WordWidth-1:0] operand_a,
    input  wire logic [e8alu_pkg::WordWidth-1:0] operand_b,
    input  wire e8alu_pkg::flags_t               flags_in,
    output e8alu_pkg::alu_result_t               result
);

    import e8alu_pkg::*;

    logic [ByteWidth-1:0] a;
    logic [ByteWidth-1:0] b;
    logic                 cin;
    logic [ByteWidth:0]   add8;
    logic [4:0]           add_half;
    logic [ByteWidth:0]   sub8;
    logic [4:0]           sub_half;
    logic [ByteWidth-1:0] inc8;
    logic [ByteWidth-1:0] dec8;
    logic [ByteWidth-1:0] daa_adj;
    logic [ByteWidth-1:0] daa_val;
    logic                 daa_carry;
    logic [WordWidth:0]   add16;
    logic [12:0]          add16_half;
    logic [WordWidth-1:0] sp_sum;
    logic [4:0]           sp_half;
    logic [ByteWidth:0]   sp_carry;
    logic [WordWidth-1:0] val;
    logic                 wb;
    flags_t               f;

    assign a = operand_a[ByteWidth-1:0];
    assign b = operand_b[ByteWidth-1:0];

    always_comb begin
        cin = 1'b0;
        if ((mode == MODE_ADC) || (mode == MODE_SBC)) begin
            cin = flags_in.c;
        end
    end

    assign add8     = {1'b0, a} + {1'b0, b} + {{ByteWidth{1'b0}}, cin};
    assign add_half = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, cin};
    assign sub8     = {1'b0, a} - {1'b0, b} - {{ByteWidth{1'b0}}, cin};
    assign sub_half = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, cin};
    assign inc8     = a + 8'd1;
    assign dec8     = a - 8'd1;

    always_comb begin
        daa_adj   = '0;
        daa_carry = flags_in.c;
        if (flags_in.h || (!flags_in.n && (a[3:0] > NibbleMax))) begin
            daa_adj = DaaLowAdj;
        end
        if (flags_in.c || (!flags_in.n && (a > DaaLimit))) begin
            daa_adj   = daa_adj | DaaHighAdj;
            daa_carry = 1'b1;
        end
        daa_val = flags_in.n ? (a - daa_adj) : (a + daa_adj);
    end

    assign add16      = {1'b0, operand_a} + {1'b0, operand_b};
    assign add16_half = {1'b0, operand_a[11:0]} + {1'b0, operand_b[11:0]};
    assign sp_sum     = operand_a + {{ByteWidth{b[ByteWidth-1]}}, b};
    assign sp_half    = {1'b0, operand_a[3:0]} + {1'b0, b[3:0]};
    assign sp_carry   = {1'b0, operand_a[ByteWidth-1:0]} + {1'b0, b};

    always_comb begin
        val = '0;
        wb  = 1'b1;
        f   = flags_in;
        case (mode_t'(mode))
            MODE_ADD, MODE_ADC: begin
                val = {8'b0, add8[ByteWidth-1:0]};
                f   = '{z: (add8[ByteWidth-1:0] == '0), n: 1'b0,
                        h: add_half[4], c: add8[ByteWidth]};
            end
            MODE_SUB, MODE_SBC: begin
                val = {8'b0, sub8[ByteWidth-1:0]};
                f   = '{z: (sub8[ByteWidth-1:0] == '0), n: 1'b1,
                        h: sub_half[4], c: sub8[ByteWidth]};
            end
            MODE_CP: begin
                wb = 1'b0;
                f  = '{z: (sub8[ByteWidth-1:0] == '0), n: 1'b1,
                       h: sub_half[4], c: sub8[ByteWidth]};
            end
            MODE_AND: begin
                val = {8'b0, a & b};
                f   = '{z: ((a & b) == '0), n: 1'b0, h: 1'b1, c: 1'b0};
            end
            MODE_XOR: begin
                val = {8'b0, a ^ b};
                f   = '{z: ((a ^ b) == '0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            MODE_OR: begin
                val = {8'b0, a | b};
                f   = '{z: ((a | b) == '0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            MODE_INC8: begin
                val = {8'b0, inc8};
                f   = '{z: (inc8 == '0), n: 1'b0, h: (inc8[3:0] == 4'h0),
                        c: flags_in.c};
            end
            MODE_DEC8: begin
                val = {8'b0, dec8};
                f   = '{z: (dec8 == '0), n: 1'b1, h: (dec8[3:0] == 4'hF),
                        c: flags_in.c};
            end
            MODE_RLCA: begin
                val = {8'b0, a[6:0], a[7]};
                f   = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
            end
            MODE_RRCA: begin
                val = {8'b0, a[0], a[7:1]};
                f   = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
            end
            MODE_RLA: begin
                val = {8'b0, a[6:0], flags_in.c};
                f   = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
            end
            MODE_RRA: begin
                val = {8'b0, flags_in.c, a[7:1]};
                f   = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
            end
            MODE_DAA: begin
                val = {8'b0, daa_val};
                f   = '{z: (daa_val == '0), n: flags_in.n, h: 1'b0, c: daa_carry};
            end
            MODE_CPL: begin
                val = {8'b0, ~a};
                f   = '{z: flags_in.z, n: 1'b1, h: 1'b1, c: flags_in.c};
            end
            MODE_SCF: begin
                wb = 1'b0;
                f  = '{z: flags_in.z, n: 1'b0, h: 1'b0, c: 1'b1};
            end
            MODE_CCF: begin
                wb = 1'b0;
                f  = '{z: flags_in.z, n: 1'b0, h: 1'b0, c: !flags_in.c};
            end
            MODE_ADD16: begin
                val = add16[WordWidth-1:0];
                f   = '{z: flags_in.z, n: 1'b0, h: add16_half[12],
                        c: add16[WordWidth]};
            end
            MODE_SP_E8: begin
                val = sp_sum;
                f   = '{z: 1'b0, n: 1'b0, h: sp_half[4], c: sp_carry[ByteWidth]};
            end
            MODE_INC16: begin
                val = operand_a + 16'd1;
            end
            MODE_DEC16: begin
                val = operand_a - 16'd1;
            end
            MODE_LOAD_FLAGS: begin
                val = {operand_b[WordWidth-1:4], 4'b0};
                f   = '{z: operand_b[7], n: operand_b[6], h: operand_b[5],
                        c: operand_b[4]};
            end
            default: begin
                wb = 1'b0;
            end
        endcase
    end

    assign result = '{value: val, write_back: wb, flags: f};

endmodule

`default_nettype wire

[rtl/eight_bit_alu_with_flags.sv]
`timescale 1ns / 1ps
`default_nettype none

// Execute ALU with a stored Z, N, H and C flag register.
// The slave channel takes one operation per transaction: s_tdata carries the
// mode, operand_a and operand_b. The master channel returns one transaction
// per operation with the result value, the write-back enable and the flags.
// An accepted operation lands in an input register, passes through the
// combinational ALU logic and is held in the output register, which presents
// its result on the master side.
// Throughput is one operation per cycle while the receiver keeps up; the
// flags computed for one operation are written into the flag register as it
// moves to the output register, so the next operation already sees them.
// When the receiver stalls, the output register holds its transaction and
// the input register can still take one more operation; s_tready drops only
// when both registers are full.
// A synchronous reset on aresetn clears both valid bits and the flags.
module eight_bit_alu_with_flags (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // mode [4:0], operand_a [20:5], operand_b [36:21], zero padding [39:37].
    input  wire logic [39:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // result_value [15:0], write_back [16], zero_flag [17], subtract_flag [18],
    // half_carry_flag [19], carry_flag [20], zero padding [23:21].
    output logic [23:0]      m_tdata
);

    import e8alu_pkg::*;

    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic [ModeWidth-1:0]  mode_reg;
    logic [WordWidth-1:0]  operand_a_reg;
    logic [WordWidth-1:0]  operand_b_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    alu_result_t           out_reg;
    flags_t                flags_reg;
    alu_result_t           alu_result;
    logic                  advance;
    logic                  in_accept;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign in_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    e8alu_core u_core (
        .mode      (mode_reg),
        .operand_a (operand_a_reg),
        .operand_b (operand_b_reg),
        .flags_in  (flags_reg),
        .result    (alu_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                flags_reg <= alu_result.flags;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            mode_reg      <= s_tdata[4:0];
            operand_a_reg <= s_tdata[20:5];
            operand_b_reg <= s_tdata[36:21];
        end
        if (advance) begin
            out_reg <= alu_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b0, out_reg.flags.c, out_reg.flags.h, out_reg.flags.n,
                       out_reg.flags.z, out_reg.write_back, out_reg.value};

endmodule

`default_nettype wire

[rtl/e8alu_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module e8alu_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("Result transaction visible right after reset.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Stalled result transaction changed or vanished.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("Input stalled while the receiver is ready.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("Result transaction without an operation two cycles earlier.");

endmodule

bind eight_bit_alu_with_flags e8alu_checker u_e8alu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

[test/eight_bit_alu_with_flags_tb.sv]
`timescale 1ns / 1ps

module eight_bit_alu_with_flags_tb;

    import e8alu_pkg::*;

    localparam logic [ModeWidth-1:0] ModeUnusedFirst = 5'd23;
    localparam logic [ModeWidth-1:0] ModeUnusedLast  = 5'd31;
    localparam int                   QuietLimit      = 1000;

    class alu_flag_board;
        flags_t               flags = '0;
        alu_result_t          expected_results[$];
        logic [WordWidth-1:0] last_value = '0;
        int                   failures = 0;

        function void note_operation(logic [ModeWidth-1:0] mode, logic [WordWidth-1:0] a16,
                                     logic [WordWidth-1:0] b16);
            logic [ByteWidth-1:0] a;
            logic [ByteWidth-1:0] b;
            logic [ByteWidth-1:0] v8;
            logic [ByteWidth-1:0] adj;
            logic [8:0]           r9;
            logic [4:0]           nib5;
            logic [12:0]          r13;
            logic [16:0]          r17;
            logic                 cin;
            flags_t               f;
            alu_result_t          res;
            a = a16[7:0];
            b = b16[7:0];
            f = flags;
            cin = flags.c;
            res.value = '0;
            res.write_back = 1'b1;
            case (mode)
                MODE_ADD, MODE_ADC: begin
                    if (mode == MODE_ADD) cin = 1'b0;
                    r9 = {1'b0, a} + {1'b0, b} + 9'(cin);
                    nib5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + 5'(cin);
                    res.value = {8'h00, r9[7:0]};
                    f = '{z: r9[7:0] == 8'h00, n: 1'b0, h: nib5[4], c: r9[8]};
                end
                MODE_SUB, MODE_SBC, MODE_CP: begin
                    if (mode != MODE_SBC) cin = 1'b0;
                    v8 = a - b - 8'(cin);
                    f.z = v8 == 8'h00;
                    f.n = 1'b1;
                    f.h = {1'b0, a[3:0]} < {1'b0, b[3:0]} + 5'(cin);
                    f.c = {1'b0, a} < {1'b0, b} + 9'(cin);
                    if (mode == MODE_CP) res.write_back = 1'b0;
                    else res.value = {8'h00, v8};
                end
                MODE_AND: begin
                    v8 = a & b;
                    res.value = {8'h00, v8};
                    f = '{z: v8 == 8'h00, n: 1'b0, h: 1'b1, c: 1'b0};
                end
                MODE_XOR, MODE_OR: begin
                    v8 = (mode == MODE_XOR) ? (a ^ b) : (a | b);
                    res.value = {8'h00, v8};
                    f = '{z: v8 == 8'h00, n: 1'b0, h: 1'b0, c: 1'b0};
                end
                MODE_INC8: begin
                    v8 = a + 8'd1;
                    res.value = {8'h00, v8};
                    f = '{z: v8 == 8'h00, n: 1'b0, h: v8[3:0] == 4'h0, c: flags.c};
                end
                MODE_DEC8: begin
                    v8 = a - 8'd1;
                    res.value = {8'h00, v8};
                    f = '{z: v8 == 8'h00, n: 1'b1, h: v8[3:0] == 4'hF, c: flags.c};
                end
                MODE_RLCA, MODE_RLA: begin
                    v8 = {a[6:0], (mode == MODE_RLCA) ? a[7] : cin};
                    res.value = {8'h00, v8};
                    f = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
                end
                MODE_RRCA, MODE_RRA: begin
                    v8 = {(mode == MODE_RRCA) ? a[0] : cin, a[7:1]};
                    res.value = {8'h00, v8};
                    f = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
                end
                MODE_DAA: begin
                    adj = '0;
                    if (flags.h || (!flags.n && a[3:0] > NibbleMax)) adj = DaaLowAdj;
                    if (flags.c || (!flags.n && a > DaaLimit)) begin
                        adj = adj | DaaHighAdj;
                        f.c = 1'b1;
                    end
                    v8 = flags.n ? (a - adj) : (a + adj);
                    res.value = {8'h00, v8};
                    f.z = v8 == 8'h00;
                    f.h = 1'b0;
                end
                MODE_CPL: begin
                    res.value = {8'h00, ~a};
                    f.n = 1'b1;
                    f.h = 1'b1;
                end
                MODE_SCF, MODE_CCF: begin
                    res.write_back = 1'b0;
                    f.n = 1'b0;
                    f.h = 1'b0;
                    f.c = (mode == MODE_SCF) ? 1'b1 : ~flags.c;
                end
                MODE_ADD16: begin
                    r17 = {1'b0, a16} + {1'b0, b16};
                    r13 = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
                    res.value = r17[15:0];
                    f.n = 1'b0;
                    f.h = r13[12];
                    f.c = r17[16];
                end
                MODE_SP_E8: begin
                    r17 = {1'b0, a16} + {1'b0, {8{b[7]}}, b};
                    nib5 = {1'b0, a16[3:0]} + {1'b0, b[3:0]};
                    r9 = {1'b0, a16[7:0]} + {1'b0, b};
                    res.value = r17[15:0];
                    f = '{z: 1'b0, n: 1'b0, h: nib5[4], c: r9[8]};
                end
                MODE_INC16: res.value = a16 + 16'd1;
                MODE_DEC16: res.value = a16 - 16'd1;
                MODE_LOAD_FLAGS: begin
                    res.value = {b16[15:4], 4'h0};
                    f = flags_t'(b16[7:4]);
                end
                default: res.write_back = 1'b0;
            endcase
            flags = f;
            res.flags = f;
            last_value = res.value;
            expected_results.push_back(res);
        endfunction

        function void compare_field(string name, logic [WordWidth-1:0] want,
                                    logic [WordWidth-1:0] got);
            if (want !== got) begin
                $error("%s: expected %h, got %h", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(logic [OutTdataW-1:0] word);
            alu_result_t want;
            if (expected_results.size() == 0) begin
                $error("result transaction %h arrived with no operation pending", word);
                failures++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("result_value", want.value, word[15:0]);
            compare_field("write_back", 16'(want.write_back), 16'(word[16]));
            compare_field("zero_flag", 16'(want.flags.z), 16'(word[17]));
            compare_field("subtract_flag", 16'(want.flags.n), 16'(word[18]));
            compare_field("half_carry_flag", 16'(want.flags.h), 16'(word[19]));
            compare_field("carry_flag", 16'(want.flags.c), 16'(word[20]));
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [InTdataW-1:0]  s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OutTdataW-1:0] m_tdata;

    alu_flag_board board = new;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            quiet_cycles = 0;
    mode_t         bcd_modes[4] = '{MODE_ADD, MODE_ADC, MODE_SUB, MODE_SBC};

    eight_bit_alu_with_flags u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (m_tvalid && m_tready) board.check_result(m_tdata);
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QuietLimit) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic send_op(input logic [ModeWidth-1:0] mode, input logic [WordWidth-1:0] a,
                           input logic [WordWidth-1:0] b);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, b, a, mode};
        do @(posedge aclk); while (!s_tready);
        board.note_operation(mode, a, b);
    endtask

    function automatic logic [WordWidth-1:0] rand_word();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(255));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random_op();
        logic [ByteWidth-1:0] bcd_a;
        logic [ByteWidth-1:0] bcd_b;
        if ($urandom_range(99) < 15) begin
            // A decimal add or subtract followed by the adjust of its result.
            bcd_a = {4'($urandom_range(9)), 4'($urandom_range(9))};
            bcd_b = {4'($urandom_range(9)), 4'($urandom_range(9))};
            send_op(bcd_modes[$urandom_range(3)], {8'($urandom), bcd_a}, {8'($urandom), bcd_b});
            send_op(MODE_DAA, {8'($urandom), board.last_value[7:0]}, 16'($urandom));
        end else if ($urandom_range(99) < 4) begin
            send_op(5'($urandom_range(ModeUnusedLast, ModeUnusedFirst)), rand_word(), rand_word());
        end else begin
            send_op(5'($urandom_range(MODE_LOAD_FLAGS, MODE_ADD)), rand_word(), rand_word());
        end
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int count);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count) send_random_op();
    endtask

    initial begin
        send_idle_pct = 30;
        recv_idle_pct = 78;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        send_op(MODE_ADD, 16'h00FF, 16'h0001);
        send_op(MODE_ADC, 16'hAB0F, 16'hCD00);
        send_op(MODE_SUB, 16'h1234, 16'h5634);
        send_op(MODE_CP, 16'h0000, 16'h0001);
        send_op(MODE_SBC, 16'h0010, 16'h000F);
        send_op(MODE_AND, 16'hFFF0, 16'hFF0F);
        send_op(MODE_XOR, 16'h00FF, 16'h00FF);
        send_op(MODE_OR, 16'h0080, 16'h0001);
        send_op(MODE_INC8, 16'h00FF, 16'h0000);
        send_op(MODE_DEC8, 16'h0000, 16'h0000);
        send_op(MODE_RLCA, 16'h0080, 16'h0000);
        send_op(MODE_RRCA, 16'h0001, 16'h0000);
        send_op(MODE_RLA, 16'h0080, 16'h0000);
        send_op(MODE_RRA, 16'h0001, 16'h0000);
        send_op(MODE_ADD, 16'h0045, 16'h0038);
        send_op(MODE_DAA, 16'h007D, 16'h0000);
        send_op(MODE_SUB, 16'h0042, 16'h0009);
        send_op(MODE_DAA, 16'h0039, 16'h0000);
        send_op(MODE_CPL, 16'h005A, 16'h0000);
        send_op(MODE_SCF, 16'h0000, 16'h0000);
        send_op(MODE_CCF, 16'h0000, 16'h0000);
        send_op(MODE_ADD16, 16'h0FFF, 16'hF001);
        send_op(MODE_SP_E8, 16'hFFF8, 16'h0080);
        send_op(MODE_INC16, 16'hFFFF, 16'h0000);
        send_op(MODE_DEC16, 16'h0000, 16'h0000);
        send_op(MODE_LOAD_FLAGS, 16'hFFFF, 16'hFFFF);
        send_op(ModeUnusedLast, 16'hFFFF, 16'hFFFF);

        run_phase(30, 78, 245);
        run_phase(78, 30, 245);
        run_phase(0, 0, 245);
        s_tvalid <= 1'b0;

        while (board.expected_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (board.failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
